/* rtl/tcp_passive_open_connection_engine_assert.svh */
// Assertion macros for the connection engine
`ifndef TCP_PASSIVE_OPEN_CONNECTION_ENGINE_ASSERT_SVH
`define TCP_PASSIVE_OPEN_CONNECTION_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define TPOCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TPOCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TPOCE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TPOCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tpoce_pkg.sv */
package tpoce_pkg;
    localparam int CONN_ENTRIES_DEF = 16;
    localparam int RX_WINDOW_DEF    = 14600;

    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_BAD_CSUM = 3'd1;
    localparam logic [2:0] RC_NO_CONN  = 3'd2;
    localparam logic [2:0] RC_IGNORED  = 3'd3;
    localparam logic [2:0] RC_SEQ_MISM = 3'd4;
    localparam logic [2:0] RC_FULL     = 3'd5;
    localparam logic [2:0] RC_NO_ACC   = 3'd6;
    localparam logic [2:0] RC_BAD_LEN  = 3'd7;

    localparam logic [7:0] FLAGS_SYNACK = 8'h12;
    localparam logic [7:0] FLAGS_ACK    = 8'h10;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_PSH_BIT = 3;
    localparam int FLAG_ACK_BIT = 4;

    localparam logic [1:0] REG_LISTEN_PORT = 2'd0;
    localparam logic [1:0] REG_LISTEN_EN   = 2'd1;
    localparam logic [1:0] REG_INIT_SEQ    = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [7:0]  seg_flags;
        logic [15:0] ip_total_length;
        logic [3:0]  header_words;
        logic        checksum_ok;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_code;
        logic        reply_valid;
        logic [31:0] reply_src_ip;
        logic [31:0] reply_dst_ip;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dst_port;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [7:0]  reply_flags;
        logic [3:0]  conn_index;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, start search
        logic read;     // read slot record
        logic execute;  // decide, update, build result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;
    } t_sts;
endpackage

/* rtl/tpoce_if.sv */
interface tpoce_req_if;
    logic              valid;
    logic              ready;
    tpoce_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tpoce_rsp_if.sv */
interface tpoce_rsp_if;
    logic              valid;
    logic              ready;
    tpoce_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tpoce_ram.sv */
module tpoce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/tpoce_ctrl.sv */
`include "tcp_passive_open_connection_engine_assert.svh"
module tpoce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tpoce_pkg::t_cmd   o_cmd,
    input  tpoce_pkg::t_sts   i_sts
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `TPOCE_ASSERT_NEXT(a_load_to_search, i_clk, i_rst_n, o_cmd.load, r_state == S_SEARCH)
    `TPOCE_ASSERT_NEXT(a_exec_to_out, i_clk, i_rst_n, o_cmd.execute, o_out_valid)
    `TPOCE_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)
endmodule

/* rtl/tpoce_dp.sv */
`include "tcp_passive_open_connection_engine_assert.svh"
module tpoce_dp #(
    parameter int CONN_ENTRIES = tpoce_pkg::CONN_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpoce_pkg::t_cmd   i_cmd,
    output tpoce_pkg::t_sts   o_sts,
    input  tpoce_pkg::t_req   i_req,
    output tpoce_pkg::t_rsp   o_rsp,
    input  logic [15:0]       i_listen_port,
    input  logic              i_listen_enable,
    input  logic [31:0]       i_init_seq
);
    localparam int IW = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
    localparam int CW = $clog2(CONN_ENTRIES + 1);
    localparam int RECW = 32 + 32 + 16 + 16 + 32 + 32;

    tpoce_pkg::t_req r_req;
    tpoce_pkg::t_rsp r_rsp;

    logic [CONN_ENTRIES-1:0] r_valid;
    logic [CONN_ENTRIES-1:0] r_phase;
    logic [CONN_ENTRIES-1:0] r_acc;

    // tuple store: one entry compared per cycle in the search
    logic [CW-1:0] r_scan;
    logic          r_busy;
    logic          r_found;
    logic [IW-1:0] r_hit;
    logic          r_free_found;
    logic [IW-1:0] r_free;
    logic          r_acc_found;
    logic [IW-1:0] r_acc_idx;

    logic [IW-1:0] scan_idx;
    logic [IW-1:0] slot;
    logic [95:0]   tup_rd;
    logic [95:0]   tup_wr;
    logic          tup_we;
    logic [IW-1:0] tup_waddr;
    logic [RECW-1:0] rec_rd;
    logic [RECW-1:0] rec_wr;
    logic          rec_we;
    logic [IW-1:0] rec_waddr;
    logic          r_cmp_v;
    logic [IW-1:0] r_cmp_idx;

    assign scan_idx = r_scan[IW-1:0];
    assign slot     = r_found ? r_hit : r_free;

    tpoce_ram #(.WIDTH(96), .DEPTH(CONN_ENTRIES)) u_tup (
        .i_clk(i_clk), .i_we(tup_we), .i_waddr(tup_waddr), .i_wdata(tup_wr),
        .i_raddr(scan_idx), .o_rdata(tup_rd)
    );

    tpoce_ram #(.WIDTH(RECW), .DEPTH(CONN_ENTRIES)) u_rec (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(rec_waddr), .i_wdata(rec_wr),
        .i_raddr(slot), .o_rdata(rec_rd)
    );

    logic        listening;
    logic [31:0] rec_lip, rec_rip, rec_sseq, rec_rack;
    logic [15:0] rec_lport, rec_rport;
    logic [17:0] hdr_bytes;
    logic [17:0] tot_ext;
    logic [31:0] pay_len;
    logic        bad_len;
    logic        tuple_eq;

    assign listening = i_listen_enable && (r_req.dport == i_listen_port);
    assign {rec_lip, rec_rip, rec_lport, rec_rport, rec_sseq, rec_rack} = rec_rd;
    assign hdr_bytes = 18'd20 + {12'd0, r_req.header_words, 2'b00};
    assign tot_ext   = {2'b00, r_req.ip_total_length};
    assign bad_len   = (r_req.header_words < 4'd5) || (tot_ext < hdr_bytes);
    assign pay_len   = {14'd0, tot_ext - hdr_bytes};
    assign tuple_eq  = (tup_rd == {r_req.src_ip, r_req.dst_ip, r_req.sport,
                                   r_req.dport});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    // search over the table, one slot per cycle, pipelined by the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cmp_v <= 1'b0;
        end else if (i_cmd.load) begin
            r_busy       <= 1'b1;
            r_scan       <= '0;
            r_cmp_v      <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_acc_found  <= 1'b0;
            r_hit        <= '0;
            r_free       <= '0;
            r_acc_idx    <= '0;
        end else if (r_busy) begin
            r_cmp_v   <= (r_scan < CW'(CONN_ENTRIES));
            r_cmp_idx <= scan_idx;
            if (r_scan < CW'(CONN_ENTRIES)) begin
                r_scan <= r_scan + 1'b1;
                if (!r_free_found && !r_valid[scan_idx]) begin
                    r_free_found <= 1'b1;
                    r_free       <= scan_idx;
                end
                if (!r_acc_found && r_valid[scan_idx] && r_phase[scan_idx]
                    && !r_acc[scan_idx]) begin
                    r_acc_found <= 1'b1;
                    r_acc_idx   <= scan_idx;
                end
            end
            if (r_cmp_v && !r_found && r_valid[r_cmp_idx] && tuple_eq) begin
                r_found <= 1'b1;
                r_hit   <= r_cmp_idx;
            end
            if (!r_cmp_v && r_scan == CW'(CONN_ENTRIES)) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_cmp_v <= 1'b0;
        end
    end

    assign o_sts.done = r_busy && !r_cmp_v && (r_scan == CW'(CONN_ENTRIES));

    logic [CONN_ENTRIES-1:0] n_valid, n_phase, n_acc;
    tpoce_pkg::t_rsp n_rsp;

    always_comb begin
        n_valid   = r_valid;
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_rsp     = '0;
        tup_we    = 1'b0;
        tup_waddr = slot;
        tup_wr    = {r_req.src_ip, r_req.dst_ip, r_req.sport, r_req.dport};
        rec_we    = 1'b0;
        rec_waddr = slot;
        rec_wr    = rec_rd;
        if (r_req.req_type) begin
            if (r_acc_found) begin
                n_acc[r_acc_idx] = 1'b1;
                n_rsp.result_code = tpoce_pkg::RC_OK;
                n_rsp.conn_index  = 4'(r_acc_idx);
            end else begin
                n_rsp.result_code = tpoce_pkg::RC_NO_ACC;
            end
        end else if (!r_req.checksum_ok) begin
            n_rsp.result_code = tpoce_pkg::RC_BAD_CSUM;
        end else if (!r_found) begin
            if (!listening) begin
                n_rsp.result_code = tpoce_pkg::RC_NO_CONN;
            end else if (!r_req.seg_flags[tpoce_pkg::FLAG_SYN_BIT]) begin
                n_rsp.result_code = tpoce_pkg::RC_IGNORED;
            end else if (!r_free_found) begin
                n_rsp.result_code = tpoce_pkg::RC_FULL;
            end else begin
                n_valid[r_free] = 1'b1;
                n_phase[r_free] = 1'b0;
                n_acc[r_free]   = 1'b0;
                tup_we = 1'b1;
                rec_we = 1'b1;
                rec_wr = {r_req.dst_ip, r_req.src_ip, r_req.dport, r_req.sport,
                          i_init_seq, r_req.seg_seq + 32'd1};
                n_rsp.result_code    = tpoce_pkg::RC_OK;
                n_rsp.reply_valid    = 1'b1;
                n_rsp.reply_src_ip   = r_req.dst_ip;
                n_rsp.reply_dst_ip   = r_req.src_ip;
                n_rsp.reply_src_port = r_req.dport;
                n_rsp.reply_dst_port = r_req.sport;
                n_rsp.reply_seq      = i_init_seq;
                n_rsp.reply_ack      = r_req.seg_seq + 32'd1;
                n_rsp.reply_flags    = tpoce_pkg::FLAGS_SYNACK;
                n_rsp.conn_index     = 4'(r_free);
            end
        end else begin
            n_rsp.conn_index = 4'(r_hit);
            if (!r_phase[r_hit]) begin
                if (!r_req.seg_flags[tpoce_pkg::FLAG_ACK_BIT]) begin
                    n_rsp.result_code = tpoce_pkg::RC_IGNORED;
                end else if (r_req.seg_seq != rec_rack) begin
                    n_rsp.result_code = tpoce_pkg::RC_SEQ_MISM;
                end else if (!listening) begin
                    n_rsp.result_code = tpoce_pkg::RC_NO_CONN;
                end else begin
                    n_phase[r_hit] = 1'b1;
                    n_rsp.result_code = tpoce_pkg::RC_OK;
                end
            end else begin
                if (r_req.seg_seq != rec_rack) begin
                    n_rsp.result_code = tpoce_pkg::RC_SEQ_MISM;
                end else if (!r_req.seg_flags[tpoce_pkg::FLAG_PSH_BIT]) begin
                    n_rsp.result_code = tpoce_pkg::RC_IGNORED;
                end else if (bad_len) begin
                    n_rsp.result_code = tpoce_pkg::RC_BAD_LEN;
                end else begin
                    rec_we = 1'b1;
                    rec_wr = {rec_lip, rec_rip, rec_lport, rec_rport, r_req.seg_ack,
                              rec_rack + pay_len};
                    n_rsp.result_code    = tpoce_pkg::RC_OK;
                    n_rsp.reply_valid    = 1'b1;
                    n_rsp.reply_src_ip   = rec_lip;
                    n_rsp.reply_dst_ip   = rec_rip;
                    n_rsp.reply_src_port = rec_lport;
                    n_rsp.reply_dst_port = rec_rport;
                    n_rsp.reply_seq      = r_req.seg_ack;
                    n_rsp.reply_ack      = rec_rack + pay_len;
                    n_rsp.reply_flags    = tpoce_pkg::FLAGS_ACK;
                end
            end
        end
        if (!i_cmd.execute) begin
            tup_we = 1'b0;
            rec_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_acc   <= '0;
        end else if (i_cmd.execute) begin
            r_valid <= n_valid;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_phase <= n_phase;
            r_rsp   <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

    `TPOCE_ASSERT_NEXT(a_valid_grows, i_clk, i_rst_n, 1'b1,
        (r_valid & $past(r_valid)) == $past(r_valid))
    `TPOCE_ASSERT_IMPL(a_acc_only_valid, i_clk, i_rst_n, 1'b1, (r_acc & ~r_valid) == '0)
    `TPOCE_ASSERT_IMPL(a_no_load_busy, i_clk, i_rst_n, r_busy, !i_cmd.execute)
endmodule

/* rtl/tcp_passive_open_connection_engine.sv */
// TCP passive-open connection engine.
// Channels: req (segment header or accept request) and rsp (one result per
// request), each a valid/ready interface; a transfer happens when both are high.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data; index 0 listen port,
// 1 listen enable, 2 initial send sequence. Write only while idle.
// One request at a time. From request transfer to rsp valid, the table
// search reads one tuple entry per cycle from the tuple RAM, then the slot
// record is read, and then the result is decided and written back.
// Reset clears the slot valid and accepted flags; the tuple and record RAMs
// hold no reset value and their contents are used only for valid slots.
// While rsp is stalled the result holds and req stays not ready.
// RX_WINDOW is the advertised window of the encoded reply, which is built
// downstream.
module tcp_passive_open_connection_engine #(
    parameter int CONN_ENTRIES = tpoce_pkg::CONN_ENTRIES_DEF,
    parameter int RX_WINDOW    = tpoce_pkg::RX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpoce_req_if.sink   req,
    tpoce_rsp_if.source rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic [15:0] o_rx_window
);
    tpoce_pkg::t_cmd cmd;
    tpoce_pkg::t_sts sts;

    logic [15:0] r_listen_port;
    logic        r_listen_en;
    logic [31:0] r_init_seq;

    assign o_rx_window = 16'(RX_WINDOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_port <= '0;
            r_listen_en   <= 1'b0;
            r_init_seq    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpoce_pkg::REG_LISTEN_PORT: r_listen_port <= i_cfg_data[15:0];
                tpoce_pkg::REG_LISTEN_EN:   r_listen_en   <= i_cfg_data[0];
                tpoce_pkg::REG_INIT_SEQ:    r_init_seq    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tpoce_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(req.valid), .o_in_ready(req.ready),
        .o_out_valid(rsp.valid), .i_out_ready(rsp.ready),
        .o_cmd(cmd), .i_sts(sts)
    );

    tpoce_dp #(.CONN_ENTRIES(CONN_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_sts(sts),
        .i_req(req.data), .o_rsp(rsp.data),
        .i_listen_port(r_listen_port), .i_listen_enable(r_listen_en),
        .i_init_seq(r_init_seq)
    );
endmodule

/* dv/tcp_passive_open_connection_engine_tb.sv */
`timescale 1ns / 1ps

module tcp_passive_open_connection_engine_tb;
    import tpoce_pkg::*;

    localparam int NSLOT = 16;
    localparam int RAND_ITEMS = 2000;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = REG_LISTEN_PORT;
    logic [31:0] i_cfg_data = '0;
    logic [15:0] o_rx_window;

    tpoce_req_if req_ch ();
    tpoce_rsp_if rsp_ch ();

    tcp_passive_open_connection_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_rx_window(o_rx_window)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    // predictor state
    logic [15:0] m_port;
    logic m_en;
    logic [31:0] m_iss;
    logic t_valid [NSLOT];
    logic t_estab [NSLOT];
    logic t_acc [NSLOT];
    logic [31:0] t_rip [NSLOT];
    logic [31:0] t_lip [NSLOT];
    logic [15:0] t_rport [NSLOT];
    logic [15:0] t_lport [NSLOT];
    logic [31:0] t_snd [NSLOT];
    logic [31:0] t_rcv [NSLOT];

    t_rsp pending_rsp[$];
    int errors = 0;
    int cycles = 0;
    bit rsp_stall_en = 1;

    function automatic t_rsp reply_of(int s, logic [7:0] fl, logic [2:0] code);
        t_rsp r;
        r = '0;
        r.result_code = code;
        r.reply_valid = 1'b1;
        r.reply_src_ip = t_lip[s];
        r.reply_dst_ip = t_rip[s];
        r.reply_src_port = t_lport[s];
        r.reply_dst_port = t_rport[s];
        r.reply_seq = t_snd[s];
        r.reply_ack = t_rcv[s];
        r.reply_flags = fl;
        r.conn_index = s[3:0];
        return r;
    endfunction

    function automatic t_rsp predict_segment(t_req q);
        t_rsp r;
        int s;
        bit found;
        bit listening;
        logic [31:0] plen;
        r = '0;
        s = 0;
        found = 0;
        listening = m_en && q.dport == m_port;
        if (q.req_type) begin
            for (int i = 0; i < NSLOT && !found; i++)
                if (t_valid[i] && t_estab[i] && !t_acc[i]) begin
                    s = i;
                    found = 1;
                end
            if (found) begin
                t_acc[s] = 1'b1;
                r.result_code = RC_OK;
                r.conn_index = s[3:0];
            end else begin
                r.result_code = RC_NO_ACC;
            end
            return r;
        end
        if (!q.checksum_ok) begin
            r.result_code = RC_BAD_CSUM;
            return r;
        end
        for (int i = 0; i < NSLOT && !found; i++)
            if (t_valid[i] && t_rip[i] == q.src_ip && t_lip[i] == q.dst_ip &&
                t_rport[i] == q.sport && t_lport[i] == q.dport) begin
                s = i;
                found = 1;
            end
        if (!found) begin
            if (!listening) r.result_code = RC_NO_CONN;
            else if (!q.seg_flags[FLAG_SYN_BIT]) r.result_code = RC_IGNORED;
            else begin
                for (int i = 0; i < NSLOT && !found; i++)
                    if (!t_valid[i]) begin
                        s = i;
                        found = 1;
                    end
                if (!found) r.result_code = RC_FULL;
                else begin
                    t_valid[s] = 1'b1;
                    t_estab[s] = 1'b0;
                    t_acc[s] = 1'b0;
                    t_rip[s] = q.src_ip;
                    t_lip[s] = q.dst_ip;
                    t_rport[s] = q.sport;
                    t_lport[s] = q.dport;
                    t_snd[s] = m_iss;
                    t_rcv[s] = q.seg_seq + 32'd1;
                    r = reply_of(s, FLAGS_SYNACK, RC_OK);
                end
            end
            return r;
        end
        r.conn_index = s[3:0];
        if (!t_estab[s]) begin
            if (!q.seg_flags[FLAG_ACK_BIT]) r.result_code = RC_IGNORED;
            else if (q.seg_seq != t_rcv[s]) r.result_code = RC_SEQ_MISM;
            else if (!listening) r.result_code = RC_NO_CONN;
            else begin
                t_estab[s] = 1'b1;
                r.result_code = RC_OK;
            end
        end else begin
            if (q.seg_seq != t_rcv[s]) r.result_code = RC_SEQ_MISM;
            else if (!q.seg_flags[FLAG_PSH_BIT]) r.result_code = RC_IGNORED;
            else if (q.header_words < 5 ||
                     q.ip_total_length < 16'd20 + 16'd4 * q.header_words)
                r.result_code = RC_BAD_LEN;
            else begin
                plen = 32'(q.ip_total_length) - 32'd20 - 32'd4 * q.header_words;
                t_rcv[s] = t_rcv[s] + plen;
                t_snd[s] = q.seg_ack;
                r = reply_of(s, FLAGS_ACK, RC_OK);
            end
        end
        return r;
    endfunction

    // mostly short gaps, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tcp_passive_open_connection_engine verification failed");
            $finish;
        end
    end

    // result side
    int rsp_gap = 0;
    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (pending_rsp.size() == 0) begin
                $display("%0t unexpected transfer: %p", $time, got);
                errors++;
            end else begin
                exp_r = pending_rsp.pop_front();
                if (got !== exp_r) begin
                    $display("%0t mismatch: expected %p actual %p", $time, exp_r, got);
                    errors++;
                end
            end
        end
        if (!rsp_stall_en) rsp_ch.ready <= 1'b1;
        else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_ch.ready && rsp_ch.valid) rsp_gap <= gap_len();
        end
    end

    bit gaps_on = 1;

    task automatic send_item(t_req q, bit has_exp, t_rsp exp_fixed);
        t_rsp p;
        int g;
        g = gaps_on ? gap_len() : 0;
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= q;
        p = predict_segment(q);
        if (has_exp && p !== exp_fixed) begin
            $display("%0t mismatch: expected %p actual %p", $time, exp_fixed, p);
            errors++;
        end
        pending_rsp.push_back(p);
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_LISTEN_PORT: m_port = val[15:0];
            REG_LISTEN_EN: m_en = val[0];
            default: m_iss = val;
        endcase
    endtask

    function automatic t_req mk(logic rt, logic [31:0] sip, logic [31:0] dip,
                                logic [15:0] sp, logic [15:0] dp, logic [31:0] sq,
                                logic [31:0] ak, logic [7:0] fl, logic [15:0] tl,
                                logic [3:0] hw, logic ck);
        t_req q;
        q.req_type = rt; q.src_ip = sip; q.dst_ip = dip; q.sport = sp;
        q.dport = dp; q.seg_seq = sq; q.seg_ack = ak; q.seg_flags = fl;
        q.ip_total_length = tl; q.header_words = hw; q.checksum_ok = ck;
        return q;
    endfunction

    typedef struct {
        t_req q;
        bit has_exp;
        t_rsp r;
    } t_row;

    // random traffic state: a small pool of peers so tuples collide
    logic [31:0] pool_ip [8];
    logic [15:0] pool_port [8];

    function automatic t_req rand_item(int phase);
        t_req q;
        int k;
        int p;
        int s;
        logic [7:0] fl;
        logic [191:0] rbits;
        rbits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        q = rbits[$bits(t_req)-1:0];
        q.req_type = 1'b0;
        q.checksum_ok = ($urandom_range(15) != 0);
        p = $urandom_range(99);
        k = $urandom_range(7);
        if (p < 8) begin
            q.req_type = 1'b1;
            return q;
        end
        if (p < 18) return q;
        q.src_ip = pool_ip[k];
        q.sport = pool_port[k] ^ 16'($urandom_range(3));
        q.dst_ip = pool_ip[(k + phase) % 8] ^ 32'h0101_0101;
        q.dport = ($urandom_range(9) == 0) ? 16'($urandom) : m_port;
        s = -1;
        for (int i = 0; i < NSLOT; i++)
            if (s < 0 && t_valid[i] && t_rip[i] == q.src_ip && t_lip[i] == q.dst_ip &&
                t_rport[i] == q.sport && t_lport[i] == q.dport) s = i;
        fl = 8'($urandom);
        if (s < 0) begin
            if ($urandom_range(4) != 0) fl[FLAG_SYN_BIT] = 1'b1;
        end else begin
            if ($urandom_range(5) != 0) q.seg_seq = t_rcv[s];
            if (!t_estab[s]) begin
                if ($urandom_range(4) != 0) fl[FLAG_ACK_BIT] = 1'b1;
            end else begin
                if ($urandom_range(4) != 0) fl[FLAG_PSH_BIT] = 1'b1;
                if ($urandom_range(4) != 0) begin
                    q.header_words = 4'($urandom_range(15, 5));
                    q.ip_total_length = 16'(20 + 4 * q.header_words + $urandom_range(1460));
                end
            end
        end
        q.seg_flags = fl;
        return q;
    endfunction

    initial begin
        t_row rows[$];
        t_rsp e;
        t_req q;
        for (int i = 0; i < NSLOT; i++) begin
            t_valid[i] = 0; t_estab[i] = 0; t_acc[i] = 0; t_rip[i] = '0; t_lip[i] = '0;
            t_rport[i] = '0; t_lport[i] = '0; t_snd[i] = '0; t_rcv[i] = '0;
        end
        m_port = '0; m_en = 1'b0; m_iss = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: at reset nothing listens
        e = '0; e.result_code = RC_NO_ACC;
        rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, e});
        e = '0; e.result_code = RC_NO_CONN;
        rows.push_back('{mk(0, '1, '1, '1, 0, '1, '1, 8'h02, '1, '1, 1), 1, e});
        e = '0; e.result_code = RC_BAD_CSUM;
        rows.push_back('{mk(0, '1, '1, '1, '1, '1, '1, '1, '1, '1, 0), 1, e});
        foreach (rows[i]) send_item(rows[i].q, rows[i].has_exp, rows[i].r);
        rows.delete();
        drain();

        write_reg(REG_LISTEN_PORT, 32'hFFFF_0050);
        write_reg(REG_LISTEN_EN, 32'h0000_0001);
        write_reg(REG_INIT_SEQ, 32'hFFFF_FFFF);
        e = '0; e.result_code = RC_IGNORED;
        rows.push_back('{mk(0, 1, 2, 3, 16'h0050, 0, 0, 8'h10, 40, 5, 1), 1, e});
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, '1, 0, 8'h02, 40, 5, 1),
                         0, e});
        e = '0; e.result_code = RC_IGNORED; e.conn_index = 0;
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 0, 0, 8'h00, 40, 5, 1),
                         1, e});
        e.result_code = RC_SEQ_MISM;
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 5, 0, 8'h10, 40, 5, 1),
                         1, e});
        e.result_code = RC_OK;
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 0, 0, 8'h10, 40, 5, 1),
                         1, e});
        e.result_code = RC_SEQ_MISM;
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 7, 0, 8'h18, 40, 5, 1),
                         1, e});
        e.result_code = RC_IGNORED;
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 0, 0, 8'h10, 40, 5, 1),
                         1, e});
        e.result_code = RC_BAD_LEN;
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 0, 0, 8'h18, 60, 4, 1),
                         1, e});
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 0, 0, 8'h18, 79, 15, 1),
                         1, e});
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 0, 9, 8'h18, '1, 15, 1),
                         0, e});
        rows.push_back('{mk(0, 32'hA, 32'hB, 16'd1000, 16'h0050, 0, 0, 8'h18, 40, 5, 1),
                         0, e});
        e = '0; e.result_code = RC_OK;
        rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, e});
        e.result_code = RC_NO_ACC;
        rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, e});
        foreach (rows[i]) send_item(rows[i].q, rows[i].has_exp, rows[i].r);
        rows.delete();
        // fill the table
        for (int i = 1; i <= NSLOT; i++)
            send_item(mk(0, 32'(i), 0, 16'(i), 16'h0050, 32'(i), 0, 8'h02, 40, 5, 1), 0, e);
        drain();
        // disabled listening: half-open ack gives no connection
        write_reg(REG_LISTEN_EN, 32'h0);
        send_item(mk(0, 32'd1, 0, 16'd1, 16'h0050, 32'd2, 0, 8'h10, 40, 5, 1), 0, e);
        drain();

        // random phases; fresh table is not possible without reset, so reuse
        // full-table behavior and vary tuples per phase
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < 8; i++) begin
                pool_ip[i] = $urandom;
                pool_port[i] = 16'($urandom);
            end
            case (ph)
                0: begin write_reg(REG_LISTEN_PORT, 32'h0); write_reg(REG_INIT_SEQ, 0); end
                1: write_reg(REG_LISTEN_PORT, 32'h0000_FFFF);
                default: begin
                    write_reg(REG_LISTEN_PORT, $urandom);
                    write_reg(REG_INIT_SEQ, $urandom);
                end
            endcase
            write_reg(REG_LISTEN_EN, (ph == 3) ? 32'h0 : 32'h1);
            gaps_on = (ph != 1);
            rsp_stall_en = (ph != 1);
            for (int n = 0; n < RAND_ITEMS / 4; n++) begin
                q = rand_item(ph);
                send_item(q, 0, e);
            end
            // hit existing slots after the table is full
            for (int n = 0; n < 40; n++) begin
                int s;
                s = $urandom_range(NSLOT - 1);
                q = mk(0, t_rip[s], t_lip[s], t_rport[s], t_lport[s], t_rcv[s],
                       $urandom, 8'($urandom) | 8'h18, 16'($urandom_range(1500, 40)),
                       4'($urandom_range(15, 5)), 1);
                send_item(q, 0, e);
                if ((n % 5) == 0) send_item(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, e);
            end
            drain();
        end

        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("tcp_passive_open_connection_engine verification clean");
        end else begin
            $display("tcp_passive_open_connection_engine verification failed");
        end
        $finish;
    end
endmodule
